FILE: rtl/sblr_pkg.sv
`default_nettype none
package sblr_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int BUF_AW = $clog2(BUF_DEPTH);
  localparam int LEN_W = 6;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

  localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
  localparam logic [6:0] BUF_LIMIT = 7'(BUF_DEPTH);

  localparam logic [6:0] MAX_LEN_RST = 7'd64;
  localparam logic [7:0] START_RST = 8'h02;
  localparam logic [7:0] END_RST = 8'h03;

  localparam logic [1:0] CFG_MAX_LEN = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_END = 2'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ABORT = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_END,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD
  } back_state_t;

  typedef enum logic [1:0] {
    CMD_ABORT,
    CMD_EMPTY,
    CMD_EMIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic en;
    logic [BUF_AW-1:0] addr;
    logic [7:0] data;
  } buf_wr_t;

  function automatic logic [7:0] bcd_pair(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sblr_cmdq.sv
`default_nettype none
module sblr_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sblr_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output sblr_pkg::cmd_t     pop_data
);
  import sblr_pkg::*;

  cmd_t entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sblr_front.sv
`default_nettype none
module sblr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            in_timed_out,
  input  wire logic            cfg_valid,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [7:0]      cfg_data,
  output logic                 cmd_push,
  output sblr_pkg::cmd_t       cmd_data,
  input  wire logic            cmd_full,
  output sblr_pkg::buf_wr_t    buf_wr,
  input  wire logic            emit_done
);
  import sblr_pkg::*;

  phase_t phase_r, phase_nxt;
  logic [6:0] max_len_r;
  logic [7:0] start_r, end_r;
  logic [BUF_AW-1:0] cnt_r, cnt_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;
  logic [7:0] lrc_r, lrc_nxt;
  logic emit_busy_r, emit_busy_nxt;
  logic accept;
  logic [7:0] lo_len;
  logic [6:0] limit;
  logic reject;
  logic cnt_done;

  assign in_full = cmd_full || (phase_r == PH_PAYLOAD && emit_busy_r);
  assign accept = in_push && !in_full;
  assign lo_len = bcd_pair(in_rx_byte);
  assign limit = (max_len_r < BUF_LIMIT) ? max_len_r : BUF_LIMIT;
  assign reject = (hi_r != 8'd0) || (({1'b0, lo_len} + FRAME_OVERHEAD) > {2'b0, limit});
  assign cnt_done = ({1'b0, cnt_r} + 7'd1) >= {1'b0, flen_r};

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_timed_out) begin
        phase_nxt = PH_HUNT;
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (in_rx_byte == start_r) phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: phase_nxt = PH_LEN_LO;
          PH_LEN_LO: begin
            if (reject) phase_nxt = PH_HUNT;
            else if (lo_len == 8'd0) phase_nxt = PH_END;
            else phase_nxt = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (cnt_done) phase_nxt = PH_END;
          end
          PH_END: begin
            if (in_rx_byte != end_r) phase_nxt = PH_HUNT;
            else phase_nxt = PH_CHECK;
          end
          PH_CHECK: phase_nxt = PH_HUNT;
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    hi_nxt = hi_r;
    flen_nxt = flen_r;
    lrc_nxt = lrc_r;
    emit_busy_nxt = emit_busy_r && !emit_done;
    cmd_push = 1'b0;
    cmd_data = '{kind: CMD_ABORT, len: '0};
    buf_wr = '{en: 1'b0, addr: cnt_r, data: in_rx_byte};
    if (accept) begin
      if (in_timed_out) begin
        cmd_push = 1'b1;
        cnt_nxt = '0;
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (in_rx_byte == start_r) begin
              lrc_nxt = 8'd0;
              cnt_nxt = '0;
            end
          end
          PH_LEN_HI: begin
            hi_nxt = in_rx_byte;
            lrc_nxt = lrc_r ^ in_rx_byte;
          end
          PH_LEN_LO: begin
            lrc_nxt = lrc_r ^ in_rx_byte;
            cnt_nxt = '0;
            if (!reject) flen_nxt = lo_len[LEN_W-1:0];
          end
          PH_PAYLOAD: begin
            buf_wr.en = 1'b1;
            lrc_nxt = lrc_r ^ in_rx_byte;
            cnt_nxt = cnt_r + 1'b1;
          end
          PH_END: begin
            if (in_rx_byte != end_r) cnt_nxt = '0;
            else lrc_nxt = lrc_r ^ in_rx_byte;
          end
          PH_CHECK: begin
            cnt_nxt = '0;
            if (in_rx_byte == lrc_r) begin
              cmd_push = 1'b1;
              cmd_data.len = flen_r;
              if (flen_r == '0) begin
                cmd_data.kind = CMD_EMPTY;
              end else begin
                cmd_data.kind = CMD_EMIT;
                emit_busy_nxt = 1'b1;
              end
            end
          end
          default: cnt_nxt = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r <= '0;
      hi_r <= '0;
      flen_r <= '0;
      lrc_r <= '0;
      emit_busy_r <= 1'b0;
      max_len_r <= MAX_LEN_RST;
      start_r <= START_RST;
      end_r <= END_RST;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      hi_r <= hi_nxt;
      flen_r <= flen_nxt;
      lrc_r <= lrc_nxt;
      emit_busy_r <= emit_busy_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_LEN: max_len_r <= cfg_data[6:0];
          CFG_START: start_r <= cfg_data;
          CFG_END: end_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sblr_back.sv
`default_nettype none
module sblr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sblr_pkg::buf_wr_t   buf_wr,
  input  wire logic                cmd_empty,
  input  wire sblr_pkg::cmd_t      cmd_data,
  output logic                     cmd_pop,
  output logic                     emit_done,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [1:0]               out_kind,
  output logic [7:0]               out_data,
  output logic                     out_last,
  output logic [5:0]               out_payload_len
);
  import sblr_pkg::*;

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_r;
  back_state_t state_r, state_nxt;
  logic [BUF_AW-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic out_valid_r;
  res_kind_t kind_r;
  logic [7:0] data_r;
  logic last_r;
  logic [LEN_W-1:0] plen_r;
  logic slot_free;
  logic is_last;
  logic load_en;
  res_kind_t load_kind;
  logic [7:0] load_data;
  logic load_last;
  logic [LEN_W-1:0] load_plen;

  assign slot_free = !out_valid_r || out_pop;
  assign is_last = ({1'b0, idx_r} + 7'd1) == {1'b0, len_r};
  assign out_empty = !out_valid_r;
  assign out_kind = kind_r;
  assign out_data = data_r;
  assign out_last = last_r;
  assign out_payload_len = plen_r;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
    rd_data_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!cmd_empty && cmd_data.kind == CMD_EMIT) state_nxt = B_READ;
      end
      B_READ: state_nxt = B_LOAD;
      B_LOAD: begin
        if (slot_free) state_nxt = is_last ? B_IDLE : B_READ;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    emit_done = 1'b0;
    load_en = 1'b0;
    load_kind = KIND_ABORT;
    load_data = 8'd0;
    load_last = 1'b1;
    load_plen = '0;
    idx_nxt = idx_r;
    len_nxt = len_r;
    case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_data.kind == CMD_EMIT) begin
            cmd_pop = 1'b1;
            idx_nxt = '0;
            len_nxt = cmd_data.len;
          end else if (slot_free) begin
            cmd_pop = 1'b1;
            load_en = 1'b1;
            load_kind = (cmd_data.kind == CMD_EMPTY) ? KIND_EMPTY : KIND_ABORT;
          end
        end
      end
      B_LOAD: begin
        if (slot_free) begin
          load_en = 1'b1;
          load_kind = KIND_PAYLOAD;
          load_data = rd_data_r;
          load_last = is_last;
          load_plen = len_r;
          emit_done = is_last;
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      len_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      len_r <= len_nxt;
      if (load_en) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      kind_r <= load_kind;
      data_r <= load_data;
      last_r <= load_last;
      plen_r <= load_plen;
    end
  end

`ifndef SYNTHESIS
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr.en |-> state_r == B_IDLE)
    else $error("payload buffer written during emission");
  a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_READ |=> state_r == B_LOAD)
    else $error("buffer read not followed by load");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_done |=> state_r == B_IDLE && out_valid_r && last_r)
    else $error("emission end without final item");
`endif

endmodule
`default_nettype wire

FILE: rtl/stx_bcd_len_lrc_frame_receiver.sv
`default_nettype none
// Items are taken while in_full is low; timeout and empty-frame results go via the command queue.
// A good frame's bytes are each read from the buffer, then loaded into the output slot once free.
// Input stalls while the two-entry command queue is full, or while a payload byte would land
// in the buffer before the previous frame's payload has been read out.
// Reset (rst_n low, synchronous) clears all control state and restores the register defaults;
// the payload buffer keeps its contents.
module stx_bcd_len_lrc_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_timed_out,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data,
  output logic            out_last,
  output logic [5:0]      out_payload_len,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import sblr_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty, emit_done;
  cmd_t cmd_in, cmd_out;
  buf_wr_t buf_wr;

  assign cfg_ready = 1'b1;

  sblr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_rx_byte   (in_rx_byte),
    .in_timed_out (in_timed_out),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_in),
    .cmd_full     (cmd_full),
    .buf_wr       (buf_wr),
    .emit_done    (emit_done)
  );

  sblr_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .pop_data  (cmd_out)
  );

  sblr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .buf_wr          (buf_wr),
    .cmd_empty       (cmd_empty),
    .cmd_data        (cmd_out),
    .cmd_pop         (cmd_pop),
    .emit_done       (emit_done),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_last        (out_last),
    .out_payload_len (out_payload_len)
  );

endmodule
`default_nettype wire
